[sv/multi_voice_sample_mixer_assert.svh]
// Assertion macros for the sample mixer checker.
`ifndef MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH

// Implication checked in the same cycle, on clk, off during reset.
`define MVSM_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define MVSM_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mvsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

	localparam int VOICE_COUNT_DEF  = 32;
	localparam int SAMPLE_DEPTH_DEF = 262144;

	// request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam int ADDR_IN_W = 18;
	localparam int FRAMES_W  = 19;
	localparam int GAIN_W    = 16;
	localparam int STEP_W    = 24;
	localparam int POS_W     = 35;
	localparam int FRAC_W    = 16;
	localparam int SMP_W     = 16;
	// base + 2*idx can exceed 2^20 and is truncated to 20 bits
	localparam int FULL_W    = 20;

	localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sd32767;
	localparam logic signed [SMP_W-1:0] SAT_MIN = -16'sd32768;

	typedef struct packed {
		logic [ADDR_IN_W-1:0] base;
		logic [FRAMES_W-1:0]  len;
		logic                 stereo;
		logic [GAIN_W-1:0]    gain_r;
		logic [GAIN_W-1:0]    gain_l;
		logic [STEP_W-1:0]    step;
		logic [POS_W-1:0]     pos;
	} voice_rec_t;

	typedef struct packed {
		logic load;
		logic step;
	} red_ctl_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic mul_right;
		logic add_left;
		logic add_right;
	} mac_ctl_t;

endpackage

[sv/mvsm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_req_if / mvsm_frame_if
// Request and output frame channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mvsm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [17:0]        sample_addr;
	logic signed [15:0] sample_data;
	logic [18:0]        clip_frames;
	logic               clip_stereo;
	logic [15:0]        gain_left;
	logic [15:0]        gain_right;
	logic [23:0]        rate_step;

	modport source (output valid, req_type, sample_addr, sample_data, clip_frames,
		clip_stereo, gain_left, gain_right, rate_step, input ready);
	modport sink (input valid, req_type, sample_addr, sample_data, clip_frames,
		clip_stereo, gain_left, gain_right, rate_step, output ready);
endinterface

interface mvsm_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mix_left;
	logic signed [15:0] mix_right;

	modport source (output valid, mix_left, mix_right, input ready);
	modport sink (input valid, mix_left, mix_right, output ready);
endinterface

[sv/mvsm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/mvsm_addr_red.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_addr_red
// Reduces a word address modulo the sample depth, one compare/subtract a cycle while stepped.
// ----------------------------------------------------------------------------
module mvsm_addr_red import mvsm_pkg::*; #(
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
	localparam int AW = $clog2(SAMPLE_DEPTH),
	localparam int RW = ((FULL_W > AW) ? FULL_W : AW) + 1,
	localparam int STEPS = (FULL_W >= AW) ? (FULL_W - AW + 1) : 1,
	localparam int KW = (STEPS > 1) ? $clog2(STEPS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  red_ctl_t          ctl,
	input  logic [FULL_W-1:0] addr_in,
	output logic              last,
	output logic [AW-1:0]     addr_out
);
	localparam logic [RW-1:0] DEPTH_W = RW'(SAMPLE_DEPTH);

	logic [RW-1:0] r_q;
	logic [KW-1:0] k_q;
	logic [RW-1:0] sub;

	assign sub      = DEPTH_W << k_q;
	assign last     = (k_q == '0);
	assign addr_out = r_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (ctl.load) begin
			k_q <= KW'(STEPS - 1);
		end else if (ctl.step && !last) begin
			k_q <= k_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_q <= RW'(addr_in);
		end else if (ctl.step && (r_q >= sub)) begin
			r_q <= r_q - sub;
		end
	end
endmodule

[sv/mvsm_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_mac
// Shared gain multiplier and saturating stereo accumulator.
// ----------------------------------------------------------------------------
module mvsm_mac import mvsm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [SMP_W-1:0] sample_l,
	input  logic signed [SMP_W-1:0] sample_r,
	input  logic [GAIN_W-1:0]       gain_l,
	input  logic [GAIN_W-1:0]       gain_r,
	output logic signed [SMP_W-1:0] acc_left,
	output logic signed [SMP_W-1:0] acc_right
);
	localparam int PW = SMP_W + GAIN_W + 1;
	localparam int SW = PW - 12;

	logic signed [PW-1:0]    prod_q;
	logic signed [SMP_W-1:0] mul_a;
	logic signed [GAIN_W:0]  mul_b;
	logic signed [PW-1:0]    biased;
	logic signed [SW-1:0]    scaled;
	logic signed [SW:0]      sum;
	logic signed [SMP_W-1:0] acc_sel;
	logic signed [SMP_W-1:0] sat;

	assign mul_a = ctl.mul_right ? sample_r : sample_l;
	assign mul_b = $signed({1'b0, (ctl.mul_right ? gain_r : gain_l)});

	// divide by 4096 rounding toward zero
	assign biased  = prod_q[PW-1] ? (prod_q + PW'(4095)) : prod_q;
	assign scaled  = biased[PW-1:12];
	assign acc_sel = ctl.add_right ? acc_right : acc_left;
	assign sum     = (SW+1)'(acc_sel) + (SW+1)'(scaled);

	always_comb begin
		if (sum > (SW+1)'(SAT_MAX)) begin
			sat = SAT_MAX;
		end else if (sum < (SW+1)'(SAT_MIN)) begin
			sat = SAT_MIN;
		end else begin
			sat = sum[SMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= PW'(mul_a * mul_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_left  <= '0;
			acc_right <= '0;
		end else if (ctl.clear) begin
			acc_left  <= '0;
			acc_right <= '0;
		end else if (ctl.add_left) begin
			acc_left <= sat;
		end else if (ctl.add_right) begin
			acc_right <= sat;
		end
	end
endmodule

[sv/multi_voice_sample_mixer.sv]
`timescale 1ns / 1ps
// Load: S address reduction steps (3 at default depth), then the sample write; start: on accept.
// Tick: scan of each voice; an ending voice is read and freed, a playing voice is read,
// reduced, fetched, multiplied and added left and right, a stereo one fetching a second sample,
// then the frame waits until taken; one shared multiplier, reduction subtractor and read port.
// Throughput: one request at a time, not ready while a request is in work.
// Reset: all voices free, accumulators zero, sample memory contents kept undefined.
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Sequencer, voice state and sample memory of the voice mixer.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer import mvsm_pkg::*; #(
	parameter int VOICE_COUNT  = VOICE_COUNT_DEF,
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mvsm_req_if.sink     req,
	mvsm_frame_if.source frame
);
	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int VW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int RECW = $bits(voice_rec_t);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RED   = 4'd1;
	localparam logic [3:0] ST_LWR   = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_VRD   = 4'd4;
	localparam logic [3:0] ST_MADDR = 4'd5;
	localparam logic [3:0] ST_ML    = 4'd6;
	localparam logic [3:0] ST_MR    = 4'd7;
	localparam logic [3:0] ST_MULL  = 4'd8;
	localparam logic [3:0] ST_ADDL  = 4'd9;
	localparam logic [3:0] ST_ADDR  = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]             state_q;
	logic                   mode_load_q;
	logic [VW:0]            vi_q;
	logic [VOICE_COUNT-1:0] active_q;
	logic signed [SMP_W-1:0] data_q;
	voice_rec_t             rec_q;
	logic signed [SMP_W-1:0] sl_q;
	logic signed [SMP_W-1:0] sr_q;

	logic        accept;
	logic        free_found;
	logic [VW-1:0] free_idx;
	voice_rec_t  rec_rd;
	voice_rec_t  start_rec;
	voice_rec_t  wb_rec;
	logic [RECW-1:0] vram_rdata;
	logic        vram_we;
	logic [VW-1:0] vram_waddr;
	voice_rec_t  vram_wdata;
	logic [FRAMES_W-1:0] idx_rd;
	logic        ended;
	logic [FULL_W-1:0] full_addr;
	logic [FULL_W-1:0] red_in;
	logic [AW-1:0] addr_l;
	logic [AW-1:0] addr_r;
	logic [AW-1:0] mem_raddr;
	logic [SMP_W-1:0] mem_rdata;
	logic        red_last;
	logic [POS_W:0] pos_sum;
	logic [POS_W-1:0] pos_next;
	red_ctl_t    red_ctl;
	mac_ctl_t    mac_ctl;

	assign req.ready   = (state_q == ST_IDLE);
	assign accept      = req.valid && req.ready;
	assign frame.valid = (state_q == ST_OUT);

	// lowest free voice
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = VW'(i);
			end
		end
	end

	assign rec_rd    = voice_rec_t'(vram_rdata);
	assign idx_rd    = rec_rd.pos[POS_W-1:FRAC_W];
	assign ended     = (idx_rd >= rec_rd.len);
	assign full_addr = FULL_W'(rec_rd.base) +
		(rec_rd.stereo ? {idx_rd, 1'b0} : FULL_W'(idx_rd));
	assign red_in    = (state_q == ST_IDLE) ? FULL_W'(req.sample_addr) : full_addr;

	assign addr_r    = (addr_l == AW'(SAMPLE_DEPTH - 1)) ? '0 : (addr_l + 1'b1);
	assign mem_raddr = (state_q == ST_ML) ? addr_r : addr_l;

	// cursor advance, saturating at full scale
	assign pos_sum  = (POS_W+1)'(rec_q.pos) + (POS_W+1)'(rec_q.step);
	assign pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

	always_comb begin
		start_rec        = '0;
		start_rec.base   = req.sample_addr;
		start_rec.len    = req.clip_frames;
		start_rec.stereo = req.clip_stereo;
		start_rec.gain_l = req.gain_left;
		start_rec.gain_r = req.gain_right;
		start_rec.step   = req.rate_step;
		start_rec.pos    = '0;
		wb_rec           = rec_q;
		wb_rec.pos       = pos_next;
	end

	always_comb begin
		vram_we    = 1'b0;
		vram_waddr = vi_q[VW-1:0];
		vram_wdata = wb_rec;
		if (accept && (req.req_type == REQ_START) && free_found) begin
			vram_we    = 1'b1;
			vram_waddr = free_idx;
			vram_wdata = start_rec;
		end else if (state_q == ST_ADDR) begin
			vram_we = 1'b1;
		end
	end

	always_comb begin
		red_ctl.load = (accept && (req.req_type == REQ_LOAD)) ||
			((state_q == ST_VRD) && !ended);
		red_ctl.step = (state_q == ST_RED);
		mac_ctl.clear     = accept && (req.req_type == REQ_TICK);
		mac_ctl.mul_en    = (state_q == ST_MULL) || (state_q == ST_ADDL);
		mac_ctl.mul_right = (state_q == ST_ADDL);
		mac_ctl.add_left  = (state_q == ST_ADDL);
		mac_ctl.add_right = (state_q == ST_ADDR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_load_q <= 1'b0;
			vi_q        <= '0;
			active_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_LOAD: begin
								mode_load_q <= 1'b1;
								state_q     <= ST_RED;
							end
							REQ_START: begin
								if (free_found) begin
									active_q[free_idx] <= 1'b1;
								end
							end
							REQ_TICK: begin
								mode_load_q <= 1'b0;
								vi_q        <= '0;
								state_q     <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RED: begin
					if (red_last) begin
						state_q <= mode_load_q ? ST_LWR : ST_MADDR;
					end
				end
				ST_LWR: state_q <= ST_IDLE;
				ST_SCAN: begin
					if (vi_q == (VW+1)'(VOICE_COUNT)) begin
						state_q <= ST_OUT;
					end else if (!active_q[vi_q[VW-1:0]]) begin
						vi_q <= vi_q + 1'b1;
					end else begin
						state_q <= ST_VRD;
					end
				end
				ST_VRD: begin
					if (ended) begin
						active_q[vi_q[VW-1:0]] <= 1'b0;
						vi_q    <= vi_q + 1'b1;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_RED;
					end
				end
				ST_MADDR: state_q <= ST_ML;
				ST_ML:    state_q <= rec_q.stereo ? ST_MR : ST_MULL;
				ST_MR:    state_q <= ST_MULL;
				ST_MULL:  state_q <= ST_ADDL;
				ST_ADDL:  state_q <= ST_ADDR;
				ST_ADDR: begin
					vi_q    <= vi_q + 1'b1;
					state_q <= ST_SCAN;
				end
				ST_OUT: begin
					if (frame.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.sample_data;
		end
		if (state_q == ST_VRD) begin
			rec_q <= rec_rd;
		end
		if (state_q == ST_ML) begin
			sl_q <= $signed(mem_rdata);
			sr_q <= $signed(mem_rdata);
		end
		if (state_q == ST_MR) begin
			sr_q <= $signed(mem_rdata);
		end
	end

	mvsm_ram #(
		.WIDTH (RECW),
		.DEPTH (VOICE_COUNT)
	) u_voice_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (RECW'(vram_wdata)),
		.raddr (vi_q[VW-1:0]),
		.rdata (vram_rdata)
	);

	mvsm_ram #(
		.WIDTH (SMP_W),
		.DEPTH (SAMPLE_DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (state_q == ST_LWR),
		.waddr (addr_l),
		.wdata (data_q),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mvsm_addr_red #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_addr_red (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (red_ctl),
		.addr_in  (red_in),
		.last     (red_last),
		.addr_out (addr_l)
	);

	mvsm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.sample_l  (sl_q),
		.sample_r  (sr_q),
		.gain_l    (rec_q.gain_l),
		.gain_r    (rec_q.gain_r),
		.acc_left  (frame.mix_left),
		.acc_right (frame.mix_right)
	);
endmodule

[sv/mvsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_checker
// Port-level checks of the sample mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_voice_sample_mixer_assert.svh"

module mvsm_checker import mvsm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [1:0]         req_type,
	input logic               frame_valid,
	input logic               frame_ready,
	input logic signed [15:0] mix_left,
	input logic signed [15:0] mix_right
);
	logic req_acc;
	assign req_acc = req_valid && req_ready;

	`MVSM_ASSERT_NEXT(a_frame_hold, frame_valid && !frame_ready,
		frame_valid && $stable(mix_left) && $stable(mix_right), "frame dropped while stalled")
	`MVSM_ASSERT_NOW(a_busy_with_frame, frame_valid, !req_ready, "request taken with frame pending")
	`MVSM_ASSERT_NEXT(a_no_frame_wo_tick, req_acc && (req_type != REQ_TICK), !frame_valid,
		"frame without tick")
	`MVSM_ASSERT_NEXT(a_tick_busy, req_acc && (req_type == REQ_TICK), !req_ready,
		"ready right after tick")
endmodule

bind multi_voice_sample_mixer mvsm_checker u_mvsm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.mix_left    (frame.mix_left),
	.mix_right   (frame.mix_right)
);
